// File: sv/slt_pkg.sv
`timescale 1ns / 1ps
package slt_pkg;

    // Result kinds carried on tuser.
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_SYMBOL = 2'd2;

    // Token types.
    localparam logic [3:0] TT_KEYWORD  = 4'd0;
    localparam logic [3:0] TT_FUNCNAME = 4'd1;
    localparam logic [3:0] TT_VARIABLE = 4'd2;
    localparam logic [3:0] TT_DATUM    = 4'd3;
    localparam logic [3:0] TT_LPAREN   = 4'd4;
    localparam logic [3:0] TT_RPAREN   = 4'd5;
    localparam logic [3:0] TT_LBRACE   = 4'd6;
    localparam logic [3:0] TT_RBRACE   = 4'd7;
    localparam logic [3:0] TT_ASSIGN   = 4'd8;
    localparam logic [3:0] TT_AT       = 4'd9;
    localparam logic [3:0] TT_BANG     = 4'd10;
    localparam logic [3:0] TT_COMMA    = 4'd11;
    localparam logic [3:0] TT_SEMI     = 4'd12;
    localparam logic [3:0] TT_DOLLAR   = 4'd13;
    localparam logic [3:0] TT_ERROR    = 4'd14;

    // Character codes with a role of their own.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // Word length saturates here; the keyword is four bytes long.
    localparam logic [2:0] WORD_LEN_MAX = 3'd5;
    localparam logic [2:0] KEYWORD_LEN  = 3'd4;

    // Default depth of the result queue.
    localparam int QUEUE_DEPTH = 4;

    // One result beat.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] ttype;
        logic [7:0] ch;
        logic       last;
    } t_result;

    // All results caused by one input item: one or two.
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h7E) && !is_digit(c) && !is_alpha(c);
    endfunction

    // Letters of the keyword "func".
    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h66;
            2'd1:    r = 8'h75;
            2'd2:    r = 8'h6E;
            default: r = 8'h63;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] symbol_type(input logic [7:0] c);
        logic [3:0] r;
        unique case (c)
            CH_LPAREN: r = TT_LPAREN;
            CH_RPAREN: r = TT_RPAREN;
            CH_LBRACE: r = TT_LBRACE;
            CH_RBRACE: r = TT_RBRACE;
            CH_EQUAL:  r = TT_ASSIGN;
            CH_AT:     r = TT_AT;
            CH_BANG:   r = TT_BANG;
            CH_COMMA:  r = TT_COMMA;
            CH_SEMI:   r = TT_SEMI;
            CH_DOLLAR: r = TT_DOLLAR;
            default:   r = TT_ERROR;
        endcase
        return r;
    endfunction

    // Type of a word at the moment it ends.
    function automatic logic [3:0] word_type(
        input logic [2:0] wl,
        input logic       km,
        input logic       in_str,
        input logic       pv,
        input logic [3:0] pt,
        input logic       fa
    );
        logic [3:0] r;
        if (wl == KEYWORD_LEN && km) begin
            r = TT_KEYWORD;
        end else if (in_str) begin
            r = TT_DATUM;
        end else if (!pv) begin
            r = TT_VARIABLE;
        end else if (pt == TT_KEYWORD || pt == TT_AT) begin
            r = TT_FUNCNAME;
        end else if (pt == TT_ASSIGN) begin
            r = fa ? TT_VARIABLE : TT_DATUM;
        end else begin
            r = TT_VARIABLE;
        end
        return r;
    endfunction

endpackage

// File: sv/slt_front.sv
`timescale 1ns / 1ps
module slt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_char,
    input  logic               i_eoi,
    input  logic               i_full,
    output logic               o_ready,
    output logic               o_push,
    output slt_pkg::t_entry    o_entry
);
    import slt_pkg::*;

    logic       r_in_string, n_in_string;
    logic [2:0] r_wl, n_wl;
    logic       r_km, n_km;
    logic       r_fd, n_fd;
    logic       r_fa, n_fa;
    logic [3:0] r_pt, n_pt;
    logic       r_pv, n_pv;

    logic       accept;
    logic       active, quote, do_space, do_punct, join_word;
    logic       end_before, emit_sym;
    logic [3:0] wt_before, sym_t, wt_after;
    logic [2:0] j_wl;
    logic       j_km, j_fd, j_fa;
    t_result    res_end, res_sym, res_chr, res_eoi;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Classify the byte against the current lexer state.
    always_comb begin
        quote     = (i_char == CH_QUOTE);
        active    = !r_in_string || quote;
        do_space  = active && is_space(i_char);
        do_punct  = active && is_punct(i_char)
                    && !(i_char == CH_DOT && r_wl != 3'd0 && r_fd);
        join_word = !(do_space || do_punct);
        end_before = !join_word && (r_wl != 3'd0);
        emit_sym   = do_punct && !quote;
        wt_before  = word_type(r_wl, r_km, r_in_string, r_pv, r_pt, r_fa);
        sym_t      = symbol_type(i_char);

        // Word state after the byte joins the word.
        j_fd = (r_wl == 3'd0) ? is_digit(i_char) : r_fd;
        j_fa = (r_wl == 3'd0) ? is_alpha(i_char) : r_fa;
        j_km = r_km && (r_wl < KEYWORD_LEN) && (i_char == kw_char(r_wl[1:0]));
        j_wl = (r_wl < WORD_LEN_MAX) ? r_wl + 3'd1 : r_wl;
        wt_after = word_type(j_wl, j_km, r_in_string, r_pv, r_pt, j_fa);
    end

    // Build the result beats.
    always_comb begin
        res_end = '{kind: KIND_WORD,   ttype: wt_before, ch: i_char, last: !emit_sym};
        res_sym = '{kind: KIND_SYMBOL, ttype: sym_t,     ch: i_char, last: 1'b1};
        res_chr = '{kind: KIND_CHAR,   ttype: TT_KEYWORD, ch: i_char, last: !i_eoi};
        res_eoi = '{kind: KIND_WORD,   ttype: wt_after,  ch: i_char, last: 1'b1};

        o_entry = '{two: 1'b0, res0: res_chr, res1: res_eoi};
        o_push  = 1'b0;
        if (join_word) begin
            o_entry.two = i_eoi;
            o_push      = accept;
        end else if (end_before) begin
            o_entry = '{two: emit_sym, res0: res_end, res1: res_sym};
            o_push  = accept;
        end else if (emit_sym) begin
            o_entry = '{two: 1'b0, res0: res_sym, res1: res_sym};
            o_push  = accept;
        end
    end

    // Next lexer state.
    always_comb begin
        n_in_string = r_in_string;
        n_wl = r_wl;
        n_km = r_km;
        n_fd = r_fd;
        n_fa = r_fa;
        n_pt = r_pt;
        n_pv = r_pv;
        if (join_word) begin
            n_wl = j_wl;
            n_km = j_km;
            n_fd = j_fd;
            n_fa = j_fa;
            if (i_eoi) begin
                n_pt = wt_after;
                n_pv = 1'b1;
            end
        end else begin
            if (end_before) begin
                n_pt = wt_before;
                n_pv = 1'b1;
            end
            if (emit_sym) begin
                n_pt = sym_t;
                n_pv = 1'b1;
            end
            if (quote) begin
                n_in_string = !r_in_string;
            end
        end
        // Any ended word clears the word state.
        if (!join_word || i_eoi) begin
            n_wl = 3'd0;
            n_km = 1'b1;
            n_fd = 1'b0;
            n_fa = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_wl <= 3'd0;
            r_km <= 1'b1;
            r_fd <= 1'b0;
            r_fa <= 1'b0;
            r_pt <= TT_KEYWORD;
            r_pv <= 1'b0;
        end else if (accept) begin
            r_in_string <= n_in_string;
            r_wl <= n_wl;
            r_km <= n_km;
            r_fd <= n_fd;
            r_fa <= n_fa;
            r_pt <= n_pt;
            r_pv <= n_pv;
        end
    end

    // The word length never runs past its saturation point.
    a_wl_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl <= WORD_LEN_MAX)
        else $error("word length beyond saturation");

    // A word longer than the keyword can never still match it.
    a_km_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wl > KEYWORD_LEN |-> !r_km)
        else $error("keyword match held on a long word");

    // A byte that ends the input leaves no pending word behind.
    a_eoi_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eoi |=> r_wl == 3'd0)
        else $error("word pending after end of input");

    // The final beat of a pushed entry always carries the last flag.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_entry.two ? (o_entry.res1.last && !o_entry.res0.last)
                                : o_entry.res0.last))
        else $error("last flag misplaced");
endmodule

// File: sv/slt_queue.sv
`timescale 1ns / 1ps
module slt_queue #(
    parameter int Depth = slt_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slt_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output slt_pkg::t_entry o_head
);
    import slt_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_entry          r_store [Depth];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntFull);
    assign o_valid = (r_count != '0);
    assign o_head  = r_store[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrLast) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PtrLast) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntFull)
        else $error("queue count out of range");
endmodule

// File: sv/slt_back.sv
`timescale 1ns / 1ps
module slt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  slt_pkg::t_entry i_head,
    input  logic            i_ready,
    output logic            o_pop,
    output logic            o_valid,
    output slt_pkg::t_result o_res
);
    import slt_pkg::*;

    logic r_sel;
    logic beat;

    assign o_valid = i_valid;
    assign o_res   = r_sel ? i_head.res1 : i_head.res0;
    assign beat    = i_valid && i_ready;
    // An entry leaves the queue with its final beat.
    assign o_pop   = beat && (r_sel || !i_head.two);

    // Select the second beat of a two-beat entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else if (beat) begin
            r_sel <= !o_pop;
        end
    end

    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_valid && i_head.two))
        else $error("second beat selected without a two-beat entry");

    a_sel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel && !i_ready |=> r_sel)
        else $error("second beat lost under stall");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> o_res.last)
        else $error("entry popped before its last beat");
endmodule

// File: sv/script_lexer_token_classifier.sv
`timescale 1ns / 1ps
// Script lexer token classifier.
// Input stream: one source byte per beat in s_axis_tdata[7:0]; s_axis_tlast
// marks the final byte of a text, after which any pending word is flushed.
// Output stream: per beat one result. m_axis_tuser holds the result kind
// (character of a word, ended word with its type, symbol token),
// m_axis_tdata[3:0] the token type and m_axis_tdata[11:4] the byte, and
// m_axis_tlast flags the final result caused by one input byte.
// Each input byte gives zero, one or two results. The classifier takes one
// byte per cycle while the queue is not full and writes its results into
// a queue of QDepth entries; the output side drains one result per cycle
// while m_axis_tready is high. Results are registered in the queue before
// the output, and the queue absorbs bursts of bytes yielding two results.
// s_axis_tready is low only while the queue is full, so a stalled receiver
// backs up into the queue first and then holds off the input.
// Reset clears the lexer state (outside a string, no word, no previous
// token) and empties the queue. String mode and the previous token carry
// over from one text to the next.
module script_lexer_token_classifier #(
    parameter int QDepth = slt_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] token_type, [11:4] char_value, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast
);
    import slt_pkg::*;

    logic    full, push, pop, q_valid;
    t_entry  entry, head;
    t_result res;

    slt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_eoi   (s_axis_tlast),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_entry (entry)
    );

    slt_queue #(.Depth(QDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    slt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head),
        .i_ready (m_axis_tready),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = {4'd0, res.ch, res.ttype};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

import slt_pkg::*;

// Scoreboard for the lexer. It keeps its own copy of the lexer state,
// works out the result beats that each accepted source byte causes, and
// compares every output beat with the oldest beat still owed.
class token_scoreboard;
    localparam logic [31:0] KEYWORD_TEXT = "func";
    localparam logic [3:0]  NO_TYPE      = 4'd0;

    // Lexer state, at its reset values after construction.
    logic       in_str;
    logic [2:0] word_len;
    logic       kw_match;
    logic       first_digit;
    logic       first_alpha;
    logic [3:0] prev_type;
    logic       prev_valid;

    // Beats caused by the byte being lexed, then all beats still owed.
    t_result    step_q[$];
    t_result    owed_q[$];

    int         errors;
    int         kind_count[4];
    int         type_count[16];

    function new();
        in_str      = 1'b0;
        word_len    = 3'd0;
        kw_match    = 1'b1;
        first_digit = 1'b0;
        first_alpha = 1'b0;
        prev_type   = TT_KEYWORD;
        prev_valid  = 1'b0;
        errors      = 0;
        foreach (kind_count[k]) kind_count[k] = 0;
        foreach (type_count[k]) type_count[k] = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
        return c inside {[8'h09:8'h0D], 8'h20};
    endfunction

    function bit is_letter(logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function bit is_numeral(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function bit is_mark(logic [7:0] c);
        return c inside {[8'h21:8'h7E]} && !is_letter(c) && !is_numeral(c);
    endfunction

    function logic [3:0] symbol_code(logic [7:0] c);
        case (c)
            CH_LPAREN: return TT_LPAREN;
            CH_RPAREN: return TT_RPAREN;
            CH_LBRACE: return TT_LBRACE;
            CH_RBRACE: return TT_RBRACE;
            CH_EQUAL:  return TT_ASSIGN;
            CH_AT:     return TT_AT;
            CH_BANG:   return TT_BANG;
            CH_COMMA:  return TT_COMMA;
            CH_SEMI:   return TT_SEMI;
            CH_DOLLAR: return TT_DOLLAR;
            default:   return TT_ERROR;
        endcase
    endfunction

    function void owe_beat(logic [1:0] kind, logic [3:0] ttype, logic [7:0] c);
        t_result r;
        r.kind  = kind;
        r.ttype = ttype;
        r.ch    = c;
        r.last  = 1'b0;
        step_q.push_back(r);
        kind_count[kind]++;
        if (kind != KIND_CHAR) type_count[ttype]++;
    endfunction

    // Close the pending word, if any, and owe its typed beat.
    function void close_word(logic [7:0] c);
        logic [3:0] t;
        if (word_len == 3'd0) return;
        if (word_len == KEYWORD_LEN && kw_match) begin
            t = TT_KEYWORD;
        end else if (in_str) begin
            t = TT_DATUM;
        end else if (!prev_valid) begin
            // Nothing seen yet: the default type.
            t = TT_VARIABLE;
        end else begin
            case (prev_type)
                TT_KEYWORD, TT_AT: t = TT_FUNCNAME;
                TT_ASSIGN:         t = first_alpha ? TT_VARIABLE : TT_DATUM;
                default:           t = TT_VARIABLE;
            endcase
        end
        owe_beat(KIND_WORD, t, c);
        prev_type   = t;
        prev_valid  = 1'b1;
        word_len    = 3'd0;
        kw_match    = 1'b1;
        first_digit = 1'b0;
        first_alpha = 1'b0;
    endfunction

    // Lex one accepted source byte and queue the beats it causes.
    function void lex_byte(logic [7:0] c, logic eoi);
        logic joins;
        joins = 1'b1;
        step_q.delete();
        if (!in_str || c == CH_QUOTE) begin
            if (is_blank(c)) begin
                close_word(c);
                joins = 1'b0;
            end else if (is_mark(c) &&
                         !(c == CH_DOT && word_len != 3'd0 && first_digit)) begin
                close_word(c);
                if (c == CH_QUOTE) begin
                    in_str = !in_str;
                end else begin
                    owe_beat(KIND_SYMBOL, symbol_code(c), c);
                    prev_type  = symbol_code(c);
                    prev_valid = 1'b1;
                end
                joins = 1'b0;
            end
        end

        // The byte becomes part of the word and is passed on at once.
        if (joins) begin
            if (word_len == 3'd0) begin
                first_digit = is_numeral(c);
                first_alpha = is_letter(c);
            end
            if (word_len >= KEYWORD_LEN ||
                c != KEYWORD_TEXT[8 * (3 - int'(word_len)) +: 8]) begin
                kw_match = 1'b0;
            end
            if (word_len < WORD_LEN_MAX) word_len++;
            owe_beat(KIND_CHAR, NO_TYPE, c);
        end

        if (eoi) close_word(c);

        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[k]) owed_q.push_back(step_q[k]);
    endfunction

    // Compare one output beat with the oldest beat owed.
    function void check_token(logic [1:0] kind, logic [3:0] ttype, logic [7:0] c,
                              logic last);
        t_result want;
        if (owed_q.size() == 0) begin
            $error("unexpected result beat: kind %0d, type %0d, char %02h, last %0b",
                   kind, ttype, c, last);
            errors++;
            return;
        end
        want = owed_q.pop_front();
        if (want.kind !== kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
        end
        if (want.ttype !== ttype) begin
            $error("token_type: expected %0d, actual %0d", want.ttype, ttype);
            errors++;
        end
        if (want.ch !== c) begin
            $error("char_value: expected %02h, actual %02h", want.ch, c);
            errors++;
        end
        if (want.last !== last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return owed_q.size();
    endfunction
endclass

module tb_top;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } src_byte_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    localparam int RANDOM_BYTES = 1050;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [7:0] SYMBOL_BYTES [10] = '{
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_EQUAL,
        CH_AT, CH_BANG, CH_COMMA, CH_SEMI, CH_DOLLAR
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [3:0] token_type, [11:4] char_value
    logic [1:0]  m_axis_tuser;            // [1:0] result_kind
    logic        m_axis_tlast;

    rx_mode_t    rx_mode     = RX_STREAM;
    int          rx_left     = 0;
    src_byte_t   src_q[$];
    int          eoi_count   = 0;
    int          drain_waits = 0;

    token_scoreboard tokens = new();

    script_lexer_token_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the output stream hangs.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Receiver readiness: a mode is held for a random stretch of cycles.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM:   m_axis_tready <= 1'b1;
            RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= (rx_left % 16 < 10);
        endcase
    end

    // Beats on both sides are taken in one place, input first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                tokens.lex_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tokens.check_token(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                                   m_axis_tlast);
            end
        end
    end

    function automatic void add_byte(logic [7:0] c, logic eoi);
        src_byte_t b;
        b.ch  = c;
        b.eoi = eoi;
        src_q.push_back(b);
        if (eoi) eoi_count++;
    endfunction

    // Random bytes end the input now and then.
    function automatic void add_rand(logic [7:0] c);
        add_byte(c, $urandom_range(0, 59) == 0);
    endfunction

    function automatic void add_text(string s, bit rand_eoi);
        for (int k = 0; k < s.len(); k++) begin
            if (rand_eoi) add_rand(s[k]);
            else add_byte(s[k], 1'b0);
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return 8'((r < 26) ? 8'h41 + r : 8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic void add_word();
        add_rand(rand_letter());
        repeat ($urandom_range(0, 6)) begin
            add_rand(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
        end
    endfunction

    function automatic void add_number();
        repeat ($urandom_range(1, 4)) add_rand(rand_digit());
        if ($urandom_range(0, 1) == 0) begin
            add_rand(CH_DOT);
            repeat ($urandom_range(0, 3)) add_rand(rand_digit());
            if ($urandom_range(0, 4) == 0) add_rand(CH_DOT);
        end
    endfunction

    // One random piece of script text: mostly well-formed tokens, some noise.
    function automatic void add_piece();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            case ($urandom_range(0, 3))
                0, 1:    add_text("func", 1'b1);
                2:       add_text("fun", 1'b1);
                default: add_text("funcs", 1'b1);
            endcase
        end else if (pick < 28) begin
            add_word();
        end else if (pick < 38) begin
            if ($urandom_range(0, 4) == 0) add_rand(CH_DOT);
            add_number();
        end else if (pick < 48) begin
            // Quoted string with arbitrary content, usually closed.
            add_rand(CH_QUOTE);
            if ($urandom_range(0, 4) == 0) begin
                add_text("func", 1'b1);
            end else begin
                repeat ($urandom_range(0, 7)) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_QUOTE) b = CH_DOT;
                    add_rand(b);
                end
            end
            if ($urandom_range(0, 6) != 0) add_rand(CH_QUOTE);
        end else if (pick < 56) begin
            // Assignment of a name or a number.
            add_word();
            if ($urandom_range(0, 1) == 0) add_rand(8'h20);
            add_rand(CH_EQUAL);
            if ($urandom_range(0, 1) == 0) add_word();
            else add_number();
            add_rand(CH_SEMI);
        end else if (pick < 78) begin
            if ($urandom_range(0, 9) < 7) begin
                add_rand(SYMBOL_BYTES[$urandom_range(0, 9)]);
            end else begin
                do b = 8'($urandom_range(8'h21, 8'h7E));
                while (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
                add_rand(b);
            end
        end else if (pick < 95) begin
            b = 8'($urandom_range(0, 5));
            add_rand((b == 5) ? 8'h20 : 8'h09 + b);
        end else begin
            add_rand(8'($urandom_range(0, 255)));
        end
    endfunction

    // Send the source bytes in bursts with random gaps between them.
    task automatic drive_stream();
        int burst_left;
        int gap;
        int pause_at;
        burst_left = 0;
        pause_at   = src_q.size() / 2;
        for (int i = 0; i < src_q.size(); i++) begin
            if (i == pause_at) begin
                // Hold off until every owed beat has come out.
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (tokens.pending() != 0);
                drain_waits++;
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            if (burst_left > 0) burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= src_q[i].ch;
            s_axis_tlast  <= src_q[i].eoi;
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        // Directed text: default type, keyword, function name, dotted number,
        // word after '=', keyword inside a string, then an unterminated
        // string ended by a high byte at end of input.
        add_text("ab\tfunc f(1.5=y)\"func\"{\"", 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        while (src_q.size() < RANDOM_BYTES + 25) add_piece();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_stream();
        // The final byte is lexed at the edge it is taken, so wait past that edge before polling.
        @(posedge i_clk);
        while (tokens.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Lexed %0d bytes (%0d end-of-input marks, %0d drain pauses): %0d word bytes,",
                 src_q.size(), eoi_count, drain_waits, tokens.kind_count[KIND_CHAR]);
        $display("%0d typed words (%0d keywords, %0d function names, %0d data), %0d symbols.",
                 tokens.kind_count[KIND_WORD], tokens.type_count[TT_KEYWORD],
                 tokens.type_count[TT_FUNCNAME], tokens.type_count[TT_DATUM],
                 tokens.kind_count[KIND_SYMBOL]);
        if (tokens.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
